[rtl/css_pkg.sv]
// Shared types and constants for the cosine similarity scorer.
`timescale 1ns / 1ps
package css_pkg;
  localparam int SumW = 40;
  localparam int RootW = 20;
  localparam int ProdW = 40;
  localparam int QuotW = 15;
  localparam int OneQ14 = 16384;
  localparam logic [SumW-1:0] SqMax = {SumW{1'b1}};
  localparam logic signed [SumW-1:0] DotMax = {1'b0, {(SumW-1){1'b1}}};

  typedef struct packed {
    logic signed [15:0] similarity;
    logic [15:0] row_number;
    logic zero_norm;
  } css_result_t;

  typedef struct packed {
    logic action;
    logic signed [15:0] feature_value;
    logic last_element;
  } css_request_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;       // consume the held request (element step)
    logic start_row_end;  // start the square root sequence
    logic sqrt_step;
    logic div_step;
    logic div_init;
    logic finish;       // capture result
  } css_cmd_t;

  typedef struct packed {
    logic row_end;      // accepted element closes a row
  } css_status_t;
endpackage

[rtl/css_stream_if.sv]
// Valid/ready channel interface carrying one request or result.
`timescale 1ns / 1ps
interface css_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/css_datapath.sv]
// Datapath: reference store, accumulators, square roots and divider.
`timescale 1ns / 1ps
module css_datapath import css_pkg::*; #(
  parameter int MAX_FEATURES = 64,
  parameter int PosW = 7
) (
  input  logic clk,
  input  logic rst,
  input  css_request_t req,
  input  css_cmd_t cmd,
  output css_status_t status,
  output css_result_t result
);
  localparam int AddrW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FEATURES);

  logic signed [15:0] reference_store [MAX_FEATURES];
  logic [PosW-1:0] reference_length;
  logic [SumW-1:0] reference_square_sum;
  logic signed [SumW-1:0] dot_accumulator;
  logic [SumW-1:0] row_square_sum;
  logic [PosW-1:0] element_position;
  logic [15:0] row_counter;
  logic loading_reference;

  // Element stage 1: read reference and form products.
  logic signed [15:0] ref_q;
  logic signed [31:0] sq_full, prod_full;
  logic in_range;
  logic [SumW:0] sq_sum_ext, rsq_sum_ext;
  logic signed [SumW:0] dot_ext;

  assign sq_full = 32'(req.feature_value) * 32'(req.feature_value);
  assign in_range = (element_position < reference_length) &&
                    (element_position < MaxPos);
  always_ff @(posedge clk) begin
    ref_q <= reference_store[element_position[AddrW-1:0]];
  end
  assign prod_full = 32'(req.feature_value) * 32'(ref_q);
  assign status.row_end = req.action && req.last_element;

  // Saturating sums for the element step.
  assign sq_sum_ext = {1'b0, reference_square_sum} + (SumW+1)'(unsigned'(sq_full));
  assign rsq_sum_ext = {1'b0, row_square_sum} + (SumW+1)'(unsigned'(sq_full));
  assign dot_ext = (SumW+1)'(dot_accumulator) + (SumW+1)'(prod_full);

  // Row end: square roots then divide (restoring, one bit per step).
  logic [SumW-1:0] rx_ref, rx_row, rres_ref, rres_row, rbit;
  logic [RootW-1:0] nr, nc;
  logic [ProdW-1:0] divisor;
  logic [SumW+14-1:0] dividend;
  logic [SumW+14:0] rem;
  logic [SumW+14-1:0] quot;
  logic neg, zero;
  logic [SumW+14:0] rem_sh;

  assign rem_sh = {rem[SumW+13:0], dividend[SumW+13]};
  assign nr = rres_ref[RootW-1:0];
  assign nc = rres_row[RootW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_length <= '0;
      reference_square_sum <= '0;
      dot_accumulator <= '0;
      row_square_sum <= '0;
      element_position <= '0;
      row_counter <= '0;
      loading_reference <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (!req.action) begin
          if (!loading_reference) begin
            reference_store[0] <= req.feature_value;
            reference_length <= PosW'(1);
            reference_square_sum <= SumW'(unsigned'(sq_full));
            row_counter <= '0;
            dot_accumulator <= '0;
            row_square_sum <= '0;
            element_position <= '0;
          end else if (reference_length < MaxPos) begin
            reference_store[reference_length[AddrW-1:0]] <= req.feature_value;
            reference_length <= reference_length + PosW'(1);
            reference_square_sum <= sq_sum_ext[SumW] ? SqMax : sq_sum_ext[SumW-1:0];
          end
          loading_reference <= !req.last_element;
        end else begin
          loading_reference <= 1'b0;
          if (in_range) begin
            if (dot_ext > (SumW+1)'(DotMax)) dot_accumulator <= DotMax;
            else if (dot_ext < -(SumW+1)'(DotMax)) dot_accumulator <= -DotMax;
            else dot_accumulator <= dot_ext[SumW-1:0];
          end
          row_square_sum <= rsq_sum_ext[SumW] ? SqMax : rsq_sum_ext[SumW-1:0];
          if (element_position < MaxPos) element_position <= element_position + PosW'(1);
        end
      end
      if (cmd.finish) begin
        row_counter <= row_counter + 16'd1;
        dot_accumulator <= '0;
        row_square_sum <= '0;
        element_position <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_row_end) begin
      rx_ref <= reference_square_sum;
      rx_row <= row_square_sum;
      rres_ref <= '0;
      rres_row <= '0;
      rbit <= SumW'(1) << (SumW-2);
    end else if (cmd.sqrt_step) begin
      if (rx_ref >= rres_ref + rbit) begin
        rx_ref <= rx_ref - (rres_ref + rbit);
        rres_ref <= (rres_ref >> 1) + rbit;
      end else rres_ref <= rres_ref >> 1;
      if (rx_row >= rres_row + rbit) begin
        rx_row <= rx_row - (rres_row + rbit);
        rres_row <= (rres_row >> 1) + rbit;
      end else rres_row <= rres_row >> 1;
      rbit <= rbit >> 2;
    end
    if (cmd.div_init) begin
      divisor <= ProdW'(nr) * ProdW'(nc);
      zero <= (nr == '0) || (nc == '0);
      neg <= dot_accumulator[SumW-1];
      dividend <= {(dot_accumulator[SumW-1] ? -dot_accumulator : dot_accumulator), 14'd0};
      rem <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= (SumW+15)'(divisor)) begin
        rem <= rem_sh - (SumW+15)'(divisor);
        quot <= {quot[SumW+12:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quot <= {quot[SumW+12:0], 1'b0};
      end
      dividend <= {dividend[SumW+12:0], 1'b0};
    end
  end

  logic [QuotW:0] qsat;
  always_comb begin
    qsat = (quot > (SumW+14)'(OneQ14)) ? (QuotW+1)'(OneQ14) : quot[QuotW:0];
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.zero_norm <= zero;
      result.row_number <= row_counter;
      result.similarity <= zero ? 16'sd0 :
        (neg ? -signed'({1'b0, qsat[14:0]} | (qsat[15] ? 16'h4000 : 16'h0))
             : signed'(16'(qsat)));
    end
  end
endmodule

[rtl/css_controller.sv]
// Controller: sequences element steps, square roots, division and output.
`timescale 1ns / 1ps
module css_controller import css_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  css_status_t status,
  output css_cmd_t cmd,
  output logic out_valid,
  input  logic out_ready
);
  localparam logic [2:0] S_IDLE = 3'd0, S_FETCH = 3'd1, S_EXEC = 3'd2,
                         S_SQRT = 3'd3, S_DINIT = 3'd4, S_DIV = 3'd5,
                         S_DONE = 3'd6;
  logic [2:0] state, state_next;
  logic [5:0] cnt;
  logic valid_out;

  assign in_ready = (state == S_IDLE);
  assign out_valid = valid_out;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC: begin
        cmd.accept = 1'b1;
        state_next = status.row_end ? S_SQRT : S_IDLE;
      end
      S_SQRT: begin
        if (cnt == 6'd0) cmd.start_row_end = 1'b1;
        else cmd.sqrt_step = 1'b1;
        if (cnt == 6'd20) state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 6'd53) state_next = S_DONE;
      end
      S_DONE: if (!valid_out || out_ready) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      valid_out <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= (state_next != state) ? 6'd0 : cnt + 6'd1;
      if (cmd.finish) valid_out <= 1'b1;
      else if (out_ready) valid_out <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.sqrt_step, cmd.div_step, cmd.div_init, cmd.finish}))
    else $error("conflicting commands");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.finish) else $error("finish while idle");
`endif
endmodule

[rtl/cosine_similarity_scorer.sv]
// Top level of the cosine similarity scorer.
`timescale 1ns / 1ps
// Usage: requests arrive on in_ch (action, feature_value, last_element).
// Action 0 loads reference elements (summed squares, stored); action 1
// streams a candidate row, multiplied against the stored reference.
// At a row's last element one result leaves on out_ch: Q1.14 similarity,
// row number and zero_norm flag.
// Each element passes through request capture (idle), store read (fetch)
// and accumulate (exec) states; a row end then runs a dual square root
// (setup plus 20 steps), a divider setup, a 54-step restoring divide and
// an output step that registers the result once out_ch can take it.
// The result sits in an output register; the next request is taken once
// it is written, while the result still waits for out_ch.ready.
// Reset (rst, synchronous) clears lengths, sums, counters and handshake
// state; the reference store holds stale data, never used unwritten.
// A stalled receiver holds the result; a further row end waits for it.
module cosine_similarity_scorer import css_pkg::*; #(
  parameter int MAX_FEATURES = 64
) (
  input logic clk,
  input logic rst,
  css_stream_if.sink in_ch,
  css_stream_if.source out_ch
);
  localparam int PosW = $clog2(MAX_FEATURES + 1);
  css_request_t req;
  css_cmd_t cmd;
  css_status_t status;
  css_result_t result;

  // Hold the request accepted in idle.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) req <= in_ch.payload;
  end

  css_controller u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status, .cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  css_datapath #(.MAX_FEATURES(MAX_FEATURES), .PosW(PosW)) u_dp (
    .clk, .rst, .req, .cmd, .status, .result
  );

  assign out_ch.payload = result;
endmodule
